@@ rtl/core/arp_pkg.sv @@
// shared types, constants and tables of the ar archive member parser
// no dependencies; imported by every module of the block
`default_nettype none

package arp_pkg;

  localparam int POSITION_BITS = 34;
  localparam int SIZE_BITS     = 34;
  localparam int OFFSET_BITS   = 34;
  localparam int FCNT_BITS     = 6;
  localparam int NAME_BYTES    = 16;

  localparam int MAGIC_LAST    = 7;
  localparam int NAME_LAST     = 15;
  localparam int SIZE_FIRST    = 48;
  localparam int SIZE_LAST     = 57;
  localparam int TRAILER_FIRST = 58;
  localparam int HEADER_LAST   = 59;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // parser phases
  localparam logic [1:0] PH_MAGIC  = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_PAD    = 2'd3;

  // size field parse states
  localparam logic [2:0] SP_WS       = 3'd0;
  localparam logic [2:0] SP_PLUS     = 3'd1;
  localparam logic [2:0] SP_MINUS    = 3'd2;
  localparam logic [2:0] SP_DIG_POS  = 3'd3;
  localparam logic [2:0] SP_DIG_NEG  = 3'd4;
  localparam logic [2:0] SP_DONE_POS = 3'd5;
  localparam logic [2:0] SP_DONE_NEG = 3'd6;
  localparam logic [2:0] SP_FAIL     = 3'd7;

  // final status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC     = 3'd1;
  localparam logic [2:0] ST_TRUNCATED     = 3'd2;
  localparam logic [2:0] ST_BAD_TRAILER   = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE      = 3'd4;
  localparam logic [2:0] ST_OUT_OF_BOUNDS = 3'd5;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_FINAL  = 1'b1;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_BACKTICK = 8'h60;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;

  // one queue entry: a member record, a final status, or both
  typedef struct packed {
    logic                   has_record;
    logic                   has_final;
    logic [63:0]            name_lo;
    logic [63:0]            name_hi;
    logic [4:0]             name_len;
    logic [OFFSET_BITS-1:0] offset;
    logic [SIZE_BITS-1:0]   size;
    logic [2:0]             status;
  } arp_event_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h21;
      3'd1:    b = 8'h3C;
      3'd2:    b = 8'h61;
      3'd3:    b = 8'h72;
      3'd4:    b = 8'h63;
      3'd5:    b = 8'h68;
      3'd6:    b = 8'h3E;
      3'd7:    b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sym64_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h2F;
      3'd1:    b = 8'h53;
      3'd2:    b = 8'h59;
      3'd3:    b = 8'h4D;
      3'd4:    b = 8'h36;
      3'd5:    b = 8'h34;
      3'd6:    b = 8'h2F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/arp_front.sv @@
// front end: takes archive bytes, tracks magic, headers and data, and
// classifies each byte into record and final status events; uses arp_pkg
`default_nettype none

module arp_front
  import arp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_data,
  output logic            push,
  output arp_event_t      evt
);

  logic [1:0]               phase, phase_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [FCNT_BITS-1:0]     fcnt, fcnt_next;
  logic [7:0]               name_buf [NAME_BYTES];
  logic [SIZE_BITS-1:0]     size_acc, size_acc_next;
  logic [2:0]               sp_state, sp_state_next;
  logic [SIZE_BITS-1:0]     remaining, remaining_next;
  logic [2:0]               err, err_next;
  logic                     trailer_bad, trailer_bad_next;
  logic                     pad_pending, pad_pending_next;
  logic [4:0]               trim_len, trim_len_next;
  logic [7:0]               last_byte, last_byte_next;

  logic                     name_we;

  always_comb begin
    logic                 is_digit;
    logic                 is_space;
    logic [SIZE_BITS-1:0] digit_val;
    logic [SIZE_BITS-1:0] acc_x10;
    logic [2:0]           sp_cur;
    logic [SIZE_BITS-1:0] acc_cur;
    logic                 tb_cur;
    logic                 neg;
    logic                 posv;
    logic                 special;
    logic                 sym_match;
    logic [4:0]           len2;
    logic [127:0]         name_flat;
    logic [2:0]           st;

    phase_next       = phase;
    pos_next         = pos;
    fcnt_next        = fcnt;
    size_acc_next    = size_acc;
    sp_state_next    = sp_state;
    remaining_next   = remaining;
    err_next         = err;
    trailer_bad_next = trailer_bad;
    pad_pending_next = pad_pending;
    trim_len_next    = trim_len;
    last_byte_next   = last_byte;
    name_we          = 1'b0;
    evt              = '0;
    push             = 1'b0;

    is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    is_space  = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
    digit_val = SIZE_BITS'(data_byte[3:0]);
    sp_cur    = (fcnt == '0) ? SP_WS : sp_state;
    acc_cur   = (fcnt == '0) ? '0 : size_acc;
    tb_cur    = (fcnt == '0) ? 1'b0 : trailer_bad;
    acc_x10   = (acc_cur << 3) + (acc_cur << 1) + digit_val;

    neg  = (sp_state == SP_DIG_NEG) || (sp_state == SP_DONE_NEG);
    posv = (sp_state == SP_DIG_POS) || (sp_state == SP_DONE_POS);

    sym_match = 1'b1;
    for (int i = 0; i < 7; i++) begin
      if (name_buf[i] != sym64_byte(3'(i))) sym_match = 1'b0;
    end
    special = ((trim_len == 5'd1) && (name_buf[0] == CH_SLASH)) ||
              ((trim_len == 5'd2) && (name_buf[0] == CH_SLASH) && (name_buf[1] == CH_SLASH)) ||
              ((trim_len == 5'd7) && sym_match);
    // one trailing slash goes after the spaces
    len2 = ((trim_len != '0) && (last_byte == CH_SLASH)) ? trim_len - 5'd1 : trim_len;
    for (int i = 0; i < NAME_BYTES; i++) begin
      name_flat[8*i +: 8] = (5'(i) < len2) ? name_buf[i] : 8'h00;
    end

    if (accept) begin
      if (err == ST_OK) begin
        unique case (phase)
          PH_MAGIC: begin
            if (data_byte != magic_byte(fcnt[2:0])) begin
              err_next = ST_BAD_MAGIC;
            end else if (fcnt == FCNT_BITS'(MAGIC_LAST)) begin
              phase_next = PH_HEADER;
              fcnt_next  = '0;
            end else begin
              fcnt_next = fcnt + 1'b1;
            end
          end
          PH_HEADER: begin
            sp_state_next    = sp_cur;
            size_acc_next    = acc_cur;
            trailer_bad_next = tb_cur;
            if (fcnt <= FCNT_BITS'(NAME_LAST)) begin
              name_we = 1'b1;
              if (data_byte != CH_SPACE) begin
                trim_len_next  = 5'(fcnt) + 5'd1;
                last_byte_next = data_byte;
              end else if (fcnt == '0) begin
                trim_len_next = '0;
              end
            end else if ((fcnt >= FCNT_BITS'(SIZE_FIRST)) && (fcnt <= FCNT_BITS'(SIZE_LAST))) begin
              unique case (sp_cur)
                SP_WS: begin
                  if (!is_space) begin
                    if (data_byte == CH_PLUS) begin
                      sp_state_next = SP_PLUS;
                    end else if (data_byte == CH_MINUS) begin
                      sp_state_next = SP_MINUS;
                    end else if (is_digit) begin
                      sp_state_next = SP_DIG_POS;
                      size_acc_next = digit_val;
                    end else begin
                      sp_state_next = SP_FAIL;
                    end
                  end
                end
                SP_PLUS, SP_MINUS: begin
                  if (is_digit) begin
                    sp_state_next = (sp_cur == SP_PLUS) ? SP_DIG_POS : SP_DIG_NEG;
                    size_acc_next = digit_val;
                  end else begin
                    sp_state_next = SP_FAIL;
                  end
                end
                SP_DIG_POS, SP_DIG_NEG: begin
                  if (is_digit) begin
                    size_acc_next = acc_x10;
                  end else begin
                    sp_state_next = (sp_cur == SP_DIG_POS) ? SP_DONE_POS : SP_DONE_NEG;
                  end
                end
                default: begin
                end
              endcase
            end else if (fcnt == FCNT_BITS'(TRAILER_FIRST)) begin
              trailer_bad_next = (data_byte != CH_BACKTICK);
            end else if (fcnt == FCNT_BITS'(HEADER_LAST)) begin
              trailer_bad_next = tb_cur || (data_byte != CH_NEWLINE);
            end

            if (fcnt >= FCNT_BITS'(HEADER_LAST)) begin
              fcnt_next = '0;
              // trailer first, then size sign and digits
              if (trailer_bad_next) begin
                err_next = ST_BAD_TRAILER;
              end else if (!neg && !posv) begin
                err_next = ST_BAD_SIZE;
              end else if (neg && (size_acc != '0)) begin
                err_next = ST_OUT_OF_BOUNDS;
              end else begin
                if (!special) begin
                  evt.has_record = 1'b1;
                  evt.name_lo    = name_flat[63:0];
                  evt.name_hi    = name_flat[127:64];
                  evt.name_len   = len2;
                  evt.offset     = OFFSET_BITS'(POSITION_BITS'(pos + 1'b1));
                  evt.size       = size_acc;
                end
                if (size_acc != '0) begin
                  phase_next       = PH_DATA;
                  remaining_next   = size_acc;
                  pad_pending_next = size_acc[0];
                end
              end
            end else begin
              fcnt_next = fcnt + 1'b1;
            end
          end
          PH_DATA: begin
            if (remaining != '0) remaining_next = remaining - 1'b1;
            if (remaining_next == '0) phase_next = pad_pending ? PH_PAD : PH_HEADER;
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase
      end
      pos_next = pos + 1'b1;

      if (end_of_data) begin
        st = err_next;
        if (st == ST_OK) begin
          if (phase_next == PH_MAGIC) st = ST_BAD_MAGIC;
          else if ((phase_next == PH_HEADER) && (fcnt_next != '0)) st = ST_TRUNCATED;
          else if (phase_next == PH_DATA) st = ST_OUT_OF_BOUNDS;
        end
        evt.has_final = 1'b1;
        evt.status    = st;
        // the stream ends here and the next byte opens a new archive
        phase_next       = PH_MAGIC;
        pos_next         = '0;
        fcnt_next        = '0;
        size_acc_next    = '0;
        sp_state_next    = SP_WS;
        remaining_next   = '0;
        err_next         = ST_OK;
        trailer_bad_next = 1'b0;
        pad_pending_next = 1'b0;
      end
      push = evt.has_record | evt.has_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC;
      pos         <= '0;
      fcnt        <= '0;
      size_acc    <= '0;
      sp_state    <= SP_WS;
      remaining   <= '0;
      err         <= ST_OK;
      trailer_bad <= 1'b0;
      pad_pending <= 1'b0;
      trim_len    <= '0;
      last_byte   <= '0;
    end else begin
      phase       <= phase_next;
      pos         <= pos_next;
      fcnt        <= fcnt_next;
      size_acc    <= size_acc_next;
      sp_state    <= sp_state_next;
      remaining   <= remaining_next;
      err         <= err_next;
      trailer_bad <= trailer_bad_next;
      pad_pending <= pad_pending_next;
      trim_len    <= trim_len_next;
      last_byte   <= last_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (name_we) begin
      name_buf[fcnt[3:0]] <= data_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/arp_queue.sv @@
// short event queue between the front end and the result stage
// register based, one push and one pop a cycle; uses arp_pkg
`default_nettype none

module arp_queue
  import arp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  arp_event_t      wr_evt,
  input  wire logic       pop,
  output arp_event_t      head,
  output logic            empty,
  output logic            full
);

  arp_event_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCOUNT_BITS'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_evt;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("request pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from an empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

@@ rtl/core/arp_back.sv @@
// result stage: turns queued events into result requests, record before
// final status, through an output register; uses arp_pkg
`default_nettype none

module arp_back
  import arp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  arp_event_t                   head,
  input  wire logic                    empty,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         result_kind,
  output logic [63:0]                  name_low_bytes,
  output logic [63:0]                  name_high_bytes,
  output logic [4:0]                   name_length,
  output logic [OFFSET_BITS-1:0]       member_data_offset,
  output logic [SIZE_BITS-1:0]         member_data_size,
  output logic [2:0]                   status,
  output logic                         last_result
);

  logic rec_done;
  logic can_load;
  logic ld_rec;
  logic ld_fin;

  assign can_load = !out_valid || out_ready;

  always_comb begin
    pop    = 1'b0;
    ld_rec = 1'b0;
    ld_fin = 1'b0;
    if (!empty && can_load) begin
      if (head.has_record && !rec_done) begin
        ld_rec = 1'b1;
        pop    = !head.has_final;
      end else begin
        ld_fin = 1'b1;
        pop    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rec_done  <= 1'b0;
    end else begin
      if (ld_rec || ld_fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      // record sent, final status of the same entry still to go
      if (ld_rec && head.has_final) rec_done <= 1'b1;
      else if (ld_fin) rec_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_rec) begin
      result_kind        <= KIND_RECORD;
      name_low_bytes     <= head.name_lo;
      name_high_bytes    <= head.name_hi;
      name_length        <= head.name_len;
      member_data_offset <= head.offset;
      member_data_size   <= head.size;
      status             <= ST_OK;
      last_result        <= 1'b0;
    end else if (ld_fin) begin
      result_kind        <= KIND_FINAL;
      name_low_bytes     <= '0;
      name_high_bytes    <= '0;
      name_length        <= '0;
      member_data_offset <= '0;
      member_data_size   <= '0;
      status             <= head.status;
      last_result        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ar_archive_member_parser.sv @@
// top level of the ar archive member parser
// depends on arp_pkg, arp_front, arp_queue and arp_back
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   data_byte, end_of_data
// out      output     out_valid / out_ready result_kind, name_low_bytes, name_high_bytes,
//                                           name_length, member_data_offset,
//                                           member_data_size, status, last_result
//
// one archive byte is taken each cycle while in_ready is high; the front end turns
// it into an event in the same cycle; the result passes queue, then output register
// in_ready falls only when the four-entry event queue is full
// a byte that ends a header and the stream can give two results, record then final status
// rst is synchronous; a final status also sends the front end back to the magic check
`default_nettype none

module ar_archive_member_parser
  import arp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   end_of_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        result_kind,
  output logic [63:0]                 name_low_bytes,
  output logic [63:0]                 name_high_bytes,
  output logic [4:0]                  name_length,
  output logic [OFFSET_BITS-1:0]      member_data_offset,
  output logic [SIZE_BITS-1:0]        member_data_size,
  output logic [2:0]                  status,
  output logic                        last_result
);

  logic       accept;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;
  arp_event_t evt;
  arp_event_t head;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  arp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .push        (push),
    .evt         (evt)
  );

  arp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_evt (evt),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full)
  );

  arp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (head),
    .empty              (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .result_kind        (result_kind),
    .name_low_bytes     (name_low_bytes),
    .name_high_bytes    (name_high_bytes),
    .name_length        (name_length),
    .member_data_offset (member_data_offset),
    .member_data_size   (member_data_size),
    .status             (status),
    .last_result        (last_result)
  );

`ifndef ASSERT_OFF
  a_record_ok: assert property (@(posedge clk) disable iff (rst)
      (out_valid && (result_kind == KIND_RECORD)) |-> ((status == ST_OK) && !last_result))
    else $error("member record carries a status or last flag");
  a_final_clean: assert property (@(posedge clk) disable iff (rst)
      (out_valid && (result_kind == KIND_FINAL)) |->
      (last_result && (name_length == '0) && (member_data_size == '0)))
    else $error("final status carries record fields");
  a_name_len: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (name_length <= 5'd16))
    else $error("trimmed name longer than the name field");
`endif

endmodule

`default_nettype wire
